// File: rtl/windowed_delay_pitch_shifter_assert.svh
// assertion macros for the windowed delay pitch shifter checker
// expects clk and rst in the scope of each use
`ifndef WINDOWED_DELAY_PITCH_SHIFTER_ASSERT_SVH
`define WINDOWED_DELAY_PITCH_SHIFTER_ASSERT_SVH

// property checked on every clock edge outside reset
`define WDPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define WDPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/wdps_pkg.sv
// shared constants for the windowed delay pitch shifter
// no dependencies
package wdps_pkg;

  // payload and register widths
  localparam int SAMPLE_W    = 24;
  localparam int RATIO_W     = 18;
  localparam int CFG_INDEX_W = 2;
  localparam int WIN_W       = 17;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_PITCH_RATIO = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BYPASS      = 2'd1;

  // reset value of the read step, 1.0 in Q2.16
  localparam logic [RATIO_W-1:0] RATIO_RESET = 18'd65536;

  // fixed-point constants of the window generator, Q30
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam longint unsigned ONE_Q30    = 64'd1073741824;

  // divisors (2n-1)*2n of the cosine series terms
  localparam longint unsigned TAYLOR_DIV [12] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
    64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
  };

endpackage

// File: rtl/wdps_delay_mem.sv
// single-port delay store with registered read data
// no dependencies
module wdps_delay_mem #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 24,
  parameter int AW    = 13
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one access per cycle, read returns the old contents
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/windowed_delay_pitch_shifter.sv
// top level of the windowed delay pitch shifter
// depends on wdps_pkg and wdps_delay_mem
//
// Each accepted item is written into its channel's delay store, two neighboring
// entries at the fractional read position are interpolated, and the result is
// scaled by a raised-cosine window read from an on-chip table. An item occupies
// the block for one write and two reads of the single-port delay memory, then
// two passes through one shared multiplier (bypass items and items of a channel
// without state skip these); req_ready is low during that time.
// A finished item waits in the output register, so the next item can be taken
// while it is still pending. The delay store needs no clearing pass: a per
// channel wrap flag makes entries not yet written read as zero.
module windowed_delay_pitch_shifter #(
  parameter int DELAY_DEPTH   = 4096,
  parameter int WINDOW_PERIOD = 2048,
  parameter int CHANNELS      = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  // input items
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic                                channel_in,
  input  logic signed [wdps_pkg::SAMPLE_W-1:0] sample_in,
  // result items
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic                                channel_out,
  output logic signed [wdps_pkg::SAMPLE_W-1:0] sample_out,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wdps_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [wdps_pkg::RATIO_W-1:0]        cfg_data
);

  localparam int SW        = wdps_pkg::SAMPLE_W;
  localparam int IW        = $clog2(DELAY_DEPTH);
  localparam int RPW       = IW + 16;
  localparam int PW        = $clog2(WINDOW_PERIOD);
  localparam int NCH       = (CHANNELS >= 2) ? 2 : 1;
  localparam int MEM_DEPTH = NCH * DELAY_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam bit CH1_OK    = (CHANNELS >= 2);
  localparam longint unsigned WRAP_L = longint'(DELAY_DEPTH) * 64'd65536;
  localparam logic [RPW:0]    WRAP   = (RPW+1)'(WRAP_L);
  localparam logic [IW-1:0]   IDX_LAST = IW'(DELAY_DEPTH - 1);
  localparam logic [PW-1:0]   PH_LAST  = PW'(WINDOW_PERIOD - 1);
  localparam logic [AW-1:0]   CH1_BASE = AW'(DELAY_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_RD1, S_RD2, S_DIFF, S_MUL1, S_SUM, S_MUL2, S_ROUND, S_OUT
  } state_t;

  // raised-cosine window value in Q1.16 for one phase, evaluated at elaboration
  function automatic logic [wdps_pkg::WIN_W-1:0] win_calc(input int unsigned ph);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned pi_q;
    longint unsigned half_pi;
    longint          acc;
    longint          a;
    logic            neg;
    pi_q    = wdps_pkg::TWO_PI_Q30 / 2;
    half_pi = wdps_pkg::TWO_PI_Q30 / 4;
    x   = (longint'(ph) * wdps_pkg::TWO_PI_Q30) / WINDOW_PERIOD;
    neg = 1'b0;
    if (x >= wdps_pkg::TWO_PI_Q30) x = wdps_pkg::TWO_PI_Q30 - 1;
    if (x > pi_q) x = wdps_pkg::TWO_PI_Q30 - x;
    if (x > half_pi) begin
      x   = pi_q - x;
      neg = 1'b1;
    end
    x2  = (x * x) >> 30;
    t   = wdps_pkg::ONE_Q30;
    acc = longint'(wdps_pkg::ONE_Q30);
    for (int n = 1; n <= 12; n++) begin
      t = ((t * x2) >> 30) / wdps_pkg::TAYLOR_DIV[n-1];
      if ((n % 2) == 1) acc = acc - longint'(t);
      else acc = acc + longint'(t);
    end
    if (neg) acc = -acc;
    a = longint'(wdps_pkg::ONE_Q30) + acc;
    if (a < 0) a = 0;
    if (a > 2 * longint'(wdps_pkg::ONE_Q30)) a = 2 * longint'(wdps_pkg::ONE_Q30);
    return wdps_pkg::WIN_W'((a + 16384) >>> 15);
  endfunction

  // window table, read through a register
  logic [wdps_pkg::WIN_W-1:0] win_rom [WINDOW_PERIOD];

  for (genvar g = 0; g < WINDOW_PERIOD; g++) begin : g_win
    localparam logic [wdps_pkg::WIN_W-1:0] WIN_VAL = win_calc(g);
    assign win_rom[g] = WIN_VAL;
  end

  // configuration registers
  logic [wdps_pkg::RATIO_W-1:0] pitch_ratio;
  logic                         bypass;

  // per-channel position state
  logic [RPW-1:0] read_pos  [2];
  logic [IW-1:0]  write_pos [2];
  logic [PW-1:0]  phase     [2];
  logic           wrapped   [2];

  // item and datapath registers
  state_t                      state;
  logic                        ch_q;
  logic signed [SW-1:0]        sample_q;
  logic signed [SW-1:0]        res_q;
  logic signed [SW-1:0]        s1;
  logic signed [SW:0]          diff;
  logic signed [41:0]          v;
  logic signed [59:0]          prod;
  logic [wdps_pkg::WIN_W-1:0]  win_q;

  // memory port
  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  logic [SW-1:0]        mem_rdata;
  logic [IW-1:0]        idx;

  // read indexes and whether those entries were written yet
  logic [IW-1:0]        i1;
  logic [IW-1:0]        i2;
  logic                 hit1;
  logic                 hit2;
  logic signed [SW-1:0] s2;

  // shared multiplier
  logic signed [41:0]   mul_a;
  logic signed [17:0]   mul_b;
  logic signed [59:0]   mul_p;

  // position updates
  logic [RPW:0]         rp_sum;
  logic [RPW:0]         rp_wrapped;

  // rounding and saturation
  logic signed [59:0]   rnd;
  logic signed [27:0]   r;
  logic signed [SW-1:0] r_sat;

  logic passthru;

  assign cfg_ready = 1'b1;
  assign req_ready = (state == S_IDLE);
  assign passthru  = bypass || (channel_in && !CH1_OK);

  always_comb begin
    i1   = read_pos[ch_q][RPW-1:16];
    i2   = (i1 == IDX_LAST) ? '0 : i1 + 1'b1;
    hit1 = wrapped[ch_q] || (i1 <= write_pos[ch_q]);
    hit2 = wrapped[ch_q] || (i2 <= write_pos[ch_q]);
    s2   = hit2 ? $signed(mem_rdata) : '0;
  end

  // memory address per sequencer step
  always_comb begin
    unique case (state)
      S_WRITE: idx = write_pos[ch_q];
      S_RD1:   idx = i1;
      default: idx = i2;
    endcase
    mem_we   = (state == S_WRITE);
    mem_addr = ch_q ? CH1_BASE + AW'(idx) : AW'(idx);
  end

  wdps_delay_mem #(
    .DEPTH (MEM_DEPTH),
    .WIDTH (SW),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (sample_q),
    .rdata (mem_rdata)
  );

  // operand select for the shared multiplier
  always_comb begin
    if (state == S_MUL2) begin
      mul_a = v;
      mul_b = $signed({1'b0, win_q});
    end else begin
      mul_a = 42'(diff);
      mul_b = $signed({2'b00, read_pos[ch_q][15:0]});
    end
    mul_p = mul_a * mul_b;
  end

  // read step wrap and output rounding
  always_comb begin
    rp_sum     = {1'b0, read_pos[ch_q]} + (RPW+1)'(pitch_ratio);
    rp_wrapped = (rp_sum >= WRAP) ? rp_sum - WRAP : rp_sum;
    rnd        = prod + 60'sd2147483648;
    r          = rnd[59:32];
    if (r > 28'sd8388607) r_sat = 24'sh7fffff;
    else if (r < -28'sd8388608) r_sat = 24'sh800000;
    else r_sat = r[SW-1:0];
  end

  // window table read
  always_ff @(posedge clk) begin
    win_q <= win_rom[phase[ch_q]];
  end

  // sequencer, state registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      pitch_ratio <= wdps_pkg::RATIO_RESET;
      bypass      <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        read_pos[c]  <= '0;
        write_pos[c] <= '0;
        phase[c]     <= '0;
        wrapped[c]   <= 1'b0;
      end
    end else begin
      // configuration writes
      if (cfg_valid) begin
        unique case (cfg_index)
          wdps_pkg::REG_PITCH_RATIO: pitch_ratio <= cfg_data;
          wdps_pkg::REG_BYPASS:      bypass      <= cfg_data[0];
          default: ;
        endcase
      end

      // result taken with no new item to load behind it
      if (rsp_valid && rsp_ready && (state != S_OUT)) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            ch_q     <= channel_in;
            sample_q <= sample_in;
            res_q    <= sample_in;
            state    <= passthru ? S_OUT : S_WRITE;
          end
        end
        S_WRITE: state <= S_RD1;
        S_RD1:   state <= S_RD2;
        S_RD2: begin
          s1    <= hit1 ? $signed(mem_rdata) : '0;
          state <= S_DIFF;
        end
        S_DIFF: begin
          diff  <= (SW+1)'(s2) - (SW+1)'(s1);
          state <= S_MUL1;
        end
        S_MUL1: begin
          prod  <= mul_p;
          state <= S_SUM;
        end
        S_SUM: begin
          v     <= 42'($signed({s1, 16'h0000})) + prod[41:0];
          state <= S_MUL2;
        end
        S_MUL2: begin
          prod  <= mul_p;
          state <= S_ROUND;
        end
        S_ROUND: begin
          res_q             <= r_sat;
          read_pos[ch_q]    <= rp_wrapped[RPW-1:0];
          write_pos[ch_q]   <= (write_pos[ch_q] == IDX_LAST) ? '0 : write_pos[ch_q] + 1'b1;
          phase[ch_q]       <= (phase[ch_q] == PH_LAST) ? '0 : phase[ch_q] + 1'b1;
          if (write_pos[ch_q] == IDX_LAST) begin
            wrapped[ch_q] <= 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid   <= 1'b1;
            channel_out <= ch_q;
            sample_out  <= res_q;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/wdps_checker.sv
// port-level checks for the windowed delay pitch shifter, bound to the top level
// depends on wdps_pkg and windowed_delay_pitch_shifter_assert.svh
`include "windowed_delay_pitch_shifter_assert.svh"

module wdps_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                req_valid,
  input logic                                req_ready,
  input logic                                rsp_valid,
  input logic                                rsp_ready,
  input logic                                channel_out,
  input logic signed [wdps_pkg::SAMPLE_W-1:0] sample_out
);

  logic [1:0] pending;
  logic       req_fire;
  logic       rsp_fire;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  // items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(req_fire) - 2'(rsp_fire);
    end
  end

  `WDPS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(sample_out) && $stable(channel_out), "result item changed while stalled")
  `WDPS_ASSERT(a_busy_after_accept, req_fire |=> !req_ready, "block ready right after taking an item")
  `WDPS_ASSERT(a_no_invented, rsp_fire |-> pending != 2'd0, "result item without an accepted item")
  `WDPS_ASSERT(a_one_in_flight, req_fire |-> pending <= 2'd1, "item accepted with two items in flight")
  `WDPS_ASSERT_ALWAYS(a_reset_empty, rst |=> !rsp_valid, "result valid right after reset")

endmodule

bind windowed_delay_pitch_shifter wdps_checker u_wdps_checker (.*);

// File: tb/sv/tb_windowed_delay_pitch_shifter.sv
// self-checking testbench for windowed_delay_pitch_shifter
// depends on wdps_pkg and the rtl of the block; predicts every result in place
module tb_windowed_delay_pitch_shifter;
  timeunit 1ns;
  timeprecision 1ps;

  import wdps_pkg::*;

  localparam int DELAY_DEPTH   = 4096;
  localparam int WINDOW_PERIOD = 2048;
  localparam int CHANNELS      = 2;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 832;

  localparam longint unsigned READ_WRAP = 64'(DELAY_DEPTH) << 16;

  // register indexes that the block does not implement
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

  typedef struct packed {
    logic                       channel;
    logic signed [SAMPLE_W-1:0] sample;
  } pitch_sample_t;

  logic                       clk;
  logic                       rst;
  logic                       req_valid;
  logic                       req_ready;
  logic                       channel_in;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       rsp_valid;
  logic                       rsp_ready;
  logic                       channel_out;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_INDEX_W-1:0]     cfg_index;
  logic [RATIO_W-1:0]         cfg_data;

  // predictor state
  logic signed [SAMPLE_W-1:0] delay_mem [CHANNELS][DELAY_DEPTH];
  longint unsigned            read_pos [CHANNELS];
  int unsigned                write_pos [CHANNELS];
  int unsigned                win_phase [CHANNELS];
  longint                     window_lut [WINDOW_PERIOD];
  logic [RATIO_W-1:0]         step_ratio;
  logic                       bypass_on;

  pitch_sample_t expected_samples [$];
  int            error_count = 0;
  int            cycle_count = 0;
  bit            req_gaps_on;
  bit            rsp_stalls_on;
  int            rsp_stall_left;

  windowed_delay_pitch_shifter #(
    .DELAY_DEPTH  (DELAY_DEPTH),
    .WINDOW_PERIOD(WINDOW_PERIOD),
    .CHANNELS     (CHANNELS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .channel_in (channel_in),
    .sample_in  (sample_in),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .channel_out(channel_out),
    .sample_out (sample_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("windowed_delay_pitch_shifter test failed");
      $finish;
    end
  end

  // raised-cosine gain in q1.16 from a truncated taylor cosine in q30
  function automatic longint window_gain_q16(int unsigned phase);
    longint unsigned half_turn, quarter_turn, ang, ang_sq, term, div;
    longint          acc, lvl;
    bit              negate;
    int              n;
    half_turn    = TWO_PI_Q30 / 64'd2;
    quarter_turn = TWO_PI_Q30 / 64'd4;
    ang          = (64'(phase) * TWO_PI_Q30) / 64'(WINDOW_PERIOD);
    negate       = 1'b0;
    if (ang >= TWO_PI_Q30) ang = TWO_PI_Q30 - 64'd1;
    if (ang > half_turn) ang = TWO_PI_Q30 - ang;
    if (ang > quarter_turn) begin
      ang    = half_turn - ang;
      negate = 1'b1;
    end
    ang_sq = (ang * ang) >> 30;
    term   = ONE_Q30;
    acc    = longint'(ONE_Q30);
    for (n = 1; n <= 12; n++) begin
      div  = 64'((2 * n - 1) * (2 * n));
      term = ((term * ang_sq) >> 30) / div;
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (negate) acc = -acc;
    lvl = longint'(ONE_Q30) + acc;
    if (lvl < 0) lvl = 0;
    if (lvl > 2 * longint'(ONE_Q30)) lvl = 2 * longint'(ONE_Q30);
    return (lvl + 64'sd16384) >>> 15;
  endfunction

  // expected result of one sample; advances the channel state unless bypass is on
  function automatic pitch_sample_t shift_pitch(logic ch, logic signed [SAMPLE_W-1:0] s);
    pitch_sample_t res;
    int unsigned   i1, i2;
    longint        frac, interp, prod, rounded;
    res.channel = ch;
    res.sample  = s;
    if (bypass_on) return res;
    delay_mem[ch][write_pos[ch]] = s;
    i1     = int'((read_pos[ch] >> 16) % 64'(DELAY_DEPTH));
    i2     = (i1 + 1) % DELAY_DEPTH;
    frac   = longint'(read_pos[ch] & 64'hFFFF);
    interp = longint'(delay_mem[ch][i1]) * 65536
           + (longint'(delay_mem[ch][i2]) - longint'(delay_mem[ch][i1])) * frac;
    prod    = interp * window_lut[win_phase[ch]];
    rounded = (prod + 64'sd2147483648) >>> 32;
    if (rounded > 64'sd8388607) rounded = 64'sd8388607;
    if (rounded < -64'sd8388608) rounded = -64'sd8388608;
    res.sample = rounded[SAMPLE_W-1:0];
    // position and phase updates
    read_pos[ch] += 64'(step_ratio);
    if (read_pos[ch] >= READ_WRAP) read_pos[ch] -= READ_WRAP;
    write_pos[ch] = (write_pos[ch] + 1) % DELAY_DEPTH;
    win_phase[ch] = (win_phase[ch] + 1) % WINDOW_PERIOD;
    return res;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // present one item from a falling edge and hold it until accepted
  task automatic send_sample(input logic ch, input logic signed [SAMPLE_W-1:0] s);
    int gap;
    gap = req_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid  <= 1'b1;
    channel_in <= ch;
    sample_in  <= s;
    expected_samples.push_back(shift_pitch(ch, s));
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    req_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // one register write, only while the block is idle
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [RATIO_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PITCH_RATIO: step_ratio = data;
      REG_BYPASS:      bypass_on  = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // reset settings; first item of each channel sits on the window peak
  task automatic test_reset_extremes();
    send_sample(1'b0, SAMPLE_MAX);
    send_sample(1'b1, SAMPLE_MIN);
    send_sample(1'b0, 24'sd0);
    send_sample(1'b1, -24'sd1);
    send_sample(1'b0, 24'sh555555);
    send_sample(1'b1, 24'shAAAAAA);
    drain_results();
  endtask

  // zero step, step just under 4.0, and the 0.5 and 2.0 ends of the range
  task automatic test_ratio_extremes();
    logic [RATIO_W-1:0] ratios [4];
    int                 k;
    ratios = '{18'd0, 18'h3FFFF, 18'd32768, 18'd131072};
    for (k = 0; k < 4; k++) begin
      write_reg(REG_PITCH_RATIO, ratios[k]);
      send_sample(1'b0, SAMPLE_MAX);
      send_sample(1'b1, SAMPLE_MIN);
      drain_results();
    end
  endtask

  // bypass on with all data bits set, writes to unused indexes, bypass off
  task automatic test_bypass();
    write_reg(REG_BYPASS, 18'h3FFFF);
    write_reg(REG_SPARE_2, 18'($urandom));
    write_reg(REG_SPARE_3, 18'($urandom));
    send_sample(1'b0, SAMPLE_MIN);
    send_sample(1'b1, SAMPLE_MAX);
    send_sample(1'b1, 24'sh123456);
    send_sample(1'b0, -24'sd1);
    drain_results();
    write_reg(REG_BYPASS, 18'h3FFFE);
  endtask

  // random phases, each with its own settings, idling pattern and channel mix
  task automatic test_random_stream(input int n_items);
    int                         sent, k, phase_len, pause_at, ch_bias;
    logic [RATIO_W-1:0]         ratio;
    logic [RATIO_W-1:0]         byp;
    logic                       ch;
    logic signed [SAMPLE_W-1:0] s;
    sent = 0;
    while (sent < n_items) begin
      drain_results();
      case ($urandom_range(0, 9))
        0:       ratio = 18'd32768;
        1:       ratio = 18'd131072;
        2:       ratio = 18'd0;
        3:       ratio = 18'h3FFFF;
        4:       ratio = 18'($urandom);
        default: ratio = 18'($urandom_range(32768, 131072));
      endcase
      write_reg(REG_PITCH_RATIO, ratio);
      byp    = 18'($urandom);
      byp[0] = ($urandom_range(0, 5) == 0);
      write_reg(REG_BYPASS, byp);
      req_gaps_on   = ($urandom_range(0, 3) != 0);
      rsp_stalls_on = ($urandom_range(0, 3) != 0);
      ch_bias       = $urandom_range(0, 100);
      phase_len     = $urandom_range(60, 140);
      pause_at      = $urandom_range(10, phase_len - 10);
      for (k = 0; k < phase_len && sent < n_items; k++) begin
        // hold off once per phase until the pipeline is empty
        if (k == pause_at) drain_results();
        ch = ($urandom_range(0, 99) < ch_bias);
        case ($urandom_range(0, 9))
          0:       s = SAMPLE_MAX;
          1:       s = SAMPLE_MIN;
          2, 3:    s = 24'($signed($urandom_range(0, 511)) - 256);
          default: s = 24'($urandom);
        endcase
        send_sample(ch, s);
        sent++;
      end
    end
  endtask

  // result side back-pressure
  initial begin
    rsp_ready      = 1'b0;
    rsp_stall_left = 0;
    forever begin
      @(negedge clk);
      if (rsp_stall_left > 0) begin
        rsp_ready <= 1'b0;
        rsp_stall_left--;
      end else begin
        rsp_ready <= 1'b1;
        if (rsp_stalls_on) rsp_stall_left = pick_gap();
      end
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    pitch_sample_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected result channel %0d sample %0d",
                 $time, channel_out, sample_out);
        error_count++;
      end else begin
        want = expected_samples.pop_front();
        if (channel_out !== want.channel) begin
          $display("%0t: channel_out expected %0d actual %0d",
                   $time, want.channel, channel_out);
          error_count++;
        end
        if (sample_out !== want.sample) begin
          $display("%0t: sample_out expected %0d actual %0d",
                   $time, want.sample, sample_out);
          error_count++;
        end
      end
    end
  end

  initial begin
    int p, c, d;
    rst           = 1'b1;
    req_valid     = 1'b0;
    channel_in    = 1'b0;
    sample_in     = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    req_gaps_on   = 1'b1;
    rsp_stalls_on = 1'b1;
    // predictor at its reset state
    for (p = 0; p < WINDOW_PERIOD; p++) window_lut[p] = window_gain_q16(p);
    for (c = 0; c < CHANNELS; c++) begin
      for (d = 0; d < DELAY_DEPTH; d++) delay_mem[c][d] = '0;
      read_pos[c]  = 0;
      write_pos[c] = 0;
      win_phase[c] = 0;
    end
    step_ratio = RATIO_RESET;
    bypass_on  = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_extremes();
    test_ratio_extremes();
    test_bypass();
    test_random_stream(RANDOM_ITEMS);
    drain_results();
    repeat (20) @(posedge clk);

    if (error_count == 0) begin
      $display("windowed_delay_pitch_shifter test passed");
    end else begin
      $display("windowed_delay_pitch_shifter test failed");
    end
    $finish;
  end

endmodule
